// ----- hdl/sss_pkg.sv -----
// Shared types and constants of the strided stream scatter.
// Used by sss_front, sss_back and strided_stream_scatter; no dependencies.
`timescale 1ns / 1ps

package sss_pkg;

  localparam int ENTRIES_DEF   = 16;
  localparam int LEN_BITS_DEF  = 16;
  localparam int ADDR_BITS_DEF = 32;

  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_WRITE,
    KIND_RESTART
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [3:0]  entry_index;
    logic [15:0] hop_length;
    logic [15:0] read_count;
    logic [15:0] read_length;
    logic [15:0] skip_length;
    logic [15:0] dest_offset;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETTLE_A,
    ST_CONSUME,
    ST_SETTLE_B,
    ST_EMIT
  } state_t;

endpackage

// ----- hdl/sss_front.sv -----
// Front end: accepts input transfers, classifies the opcode and queues items.
// Depends on sss_pkg.
`timescale 1ns / 1ps

module sss_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_opcode,
  input  logic [7:0]     in_data_byte,
  input  logic [3:0]     in_entry_index,
  input  logic [15:0]    in_hop_length,
  input  logic [15:0]    in_read_count,
  input  logic [15:0]    in_read_length,
  input  logic [15:0]    in_skip_length,
  input  logic [15:0]    in_dest_offset,
  output logic           q_valid,
  output sss_pkg::item_t q_item,
  input  logic           q_pop
);

  sss_pkg::item_t slot_r [2];
  logic [1:0]     count_r, count_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           accept;
  logic           push;
  logic           pop;
  sss_pkg::item_t new_item;

  assign in_stall = (count_r == 2'd2);
  assign accept   = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];
  assign pop      = q_pop && q_valid;

  always_comb begin
    new_item.data_byte   = in_data_byte;
    new_item.entry_index = in_entry_index;
    new_item.hop_length  = in_hop_length;
    new_item.read_count  = in_read_count;
    new_item.read_length = in_read_length;
    new_item.skip_length = in_skip_length;
    new_item.dest_offset = in_dest_offset;
    new_item.kind        = sss_pkg::KIND_DATA;
    push                 = accept;
    unique case (in_opcode)
      sss_pkg::OP_DATA:    new_item.kind = sss_pkg::KIND_DATA;
      sss_pkg::OP_WRITE:   new_item.kind = sss_pkg::KIND_WRITE;
      sss_pkg::OP_RESTART: new_item.kind = sss_pkg::KIND_RESTART;
      sss_pkg::OP_UNUSED:  push = 1'b0; // drop: no effect, no result
    endcase
  end

  always_comb begin
    count_nxt  = count_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ----- hdl/sss_back.sv -----
// Back end: descriptor table, progress sequencer and result register.
// Depends on sss_pkg; fed by sss_front.
`timescale 1ns / 1ps

module sss_back #(
  parameter int ENTRIES   = sss_pkg::ENTRIES_DEF,
  parameter int LEN_BITS  = sss_pkg::LEN_BITS_DEF,
  parameter int ADDR_BITS = sss_pkg::ADDR_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [4:0]     cfg_wdata,
  input  logic           q_valid,
  input  sss_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_write_valid,
  output logic [31:0]    out_dest_address,
  output logic [7:0]     out_byte_value,
  output logic           out_plan_done
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ENT_W = $clog2(ENTRIES + 1);
  localparam int LW    = LEN_BITS;
  localparam int AW    = ADDR_BITS;

  logic [LW-1:0] hop_tbl_r [ENTRIES];
  logic [LW-1:0] cnt_tbl_r [ENTRIES];
  logic [LW-1:0] rd_tbl_r  [ENTRIES];
  logic [LW-1:0] skp_tbl_r [ENTRIES];
  logic [LW-1:0] off_tbl_r [ENTRIES];

  sss_pkg::state_t state_r, state_nxt;
  logic [4:0]      entry_count_r;
  logic [ENT_W-1:0] entry_r, entry_nxt;
  logic [LW-1:0]   hop_pos_r, hop_pos_nxt;
  logic [LW-1:0]   seg_r, seg_nxt;
  logic [LW-1:0]   runs_r, runs_nxt;
  logic            skip_r, skip_nxt;
  logic            keep_r, keep_nxt;
  logic [AW-1:0]   prod_r, prod_nxt;
  logic [LW-1:0]   off_cap_r, off_cap_nxt;
  logic [LW-1:0]   seg_cap_r, seg_cap_nxt;
  logic [7:0]      byte_r, byte_nxt;

  logic            out_valid_r;
  logic            out_wv_r;
  logic [31:0]     out_addr_r;
  logic [7:0]      out_byte_r;
  logic            out_done_r;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] wr_idx;
  logic [LW-1:0]   cur_hop, cur_cnt, cur_rd, cur_skp, cur_off;
  logic [31:0]     used;
  logic            fin;
  logic            tbl_we;
  logic            emit_ok;
  logic            emit;
  logic [2*LW-1:0] mult;
  logic [AW-1:0]   addr;
  logic [LW:0]     runs_inc;

  // settle step results
  logic            st_stop;
  logic [ENT_W-1:0] st_entry;
  logic [LW-1:0]   st_hop, st_seg, st_runs;
  logic            st_skip;

  assign idx     = IDX_W'(entry_r);
  assign wr_idx  = IDX_W'(q_item.entry_index);
  assign cur_hop = hop_tbl_r[idx];
  assign cur_cnt = cnt_tbl_r[idx];
  assign cur_rd  = rd_tbl_r[idx];
  assign cur_skp = skp_tbl_r[idx];
  assign cur_off = off_tbl_r[idx];
  assign used    = (32'(entry_count_r) > 32'(ENTRIES)) ? 32'(ENTRIES) : 32'(entry_count_r);
  assign fin     = 32'(entry_r) >= used;
  assign emit_ok = !out_valid_r || !out_stall;
  assign mult    = runs_r * cur_rd;
  assign addr    = AW'(off_cap_r) + prod_r + AW'(seg_cap_r);
  assign runs_inc = {1'b0, runs_r} + {{LW{1'b0}}, 1'b1};

  // One step of passing finished or empty segments.
  always_comb begin
    st_stop  = 1'b0;
    st_entry = entry_r;
    st_hop   = hop_pos_r;
    st_seg   = seg_r;
    st_runs  = runs_r;
    st_skip  = skip_r;
    if (fin) begin
      st_stop = 1'b1;
    end else if (hop_pos_r < cur_hop) begin
      st_stop = 1'b1;
    end else if (runs_r >= cur_cnt) begin
      st_entry = entry_r + ENT_W'(1);
      st_hop   = '0;
      st_seg   = '0;
      st_runs  = '0;
      st_skip  = 1'b0;
    end else if (skip_r) begin
      if (seg_r < cur_skp) begin
        st_stop = 1'b1;
      end else begin
        st_seg  = '0;
        st_skip = 1'b0;
        st_runs = runs_inc[LW-1:0];
      end
    end else if (seg_r < cur_rd) begin
      st_stop = 1'b1;
    end else if (cur_rd == '0 && cur_skp == '0) begin
      st_seg  = '0;
      st_runs = cur_cnt;
    end else begin
      st_seg = '0;
      if (runs_inc < {1'b0, cur_cnt}) begin
        st_skip = 1'b1;
      end else begin
        st_runs = runs_inc[LW-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sss_pkg::ST_IDLE: begin
        if (q_valid && q_item.kind == sss_pkg::KIND_DATA) begin
          state_nxt = sss_pkg::ST_SETTLE_A;
        end
      end
      sss_pkg::ST_SETTLE_A: begin
        if (st_stop) begin
          state_nxt = sss_pkg::ST_CONSUME;
        end
      end
      sss_pkg::ST_CONSUME:  state_nxt = sss_pkg::ST_SETTLE_B;
      sss_pkg::ST_SETTLE_B: begin
        if (st_stop) begin
          state_nxt = sss_pkg::ST_EMIT;
        end
      end
      sss_pkg::ST_EMIT: begin
        if (emit_ok) begin
          state_nxt = sss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    tbl_we      = 1'b0;
    emit        = 1'b0;
    entry_nxt   = entry_r;
    hop_pos_nxt = hop_pos_r;
    seg_nxt     = seg_r;
    runs_nxt    = runs_r;
    skip_nxt    = skip_r;
    keep_nxt    = keep_r;
    prod_nxt    = prod_r;
    off_cap_nxt = off_cap_r;
    seg_cap_nxt = seg_cap_r;
    byte_nxt    = byte_r;
    unique case (state_r)
      sss_pkg::ST_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          unique case (q_item.kind)
            sss_pkg::KIND_WRITE: tbl_we = 32'(q_item.entry_index) < 32'(ENTRIES);
            sss_pkg::KIND_RESTART: begin
              entry_nxt   = '0;
              hop_pos_nxt = '0;
              seg_nxt     = '0;
              runs_nxt    = '0;
              skip_nxt    = 1'b0;
            end
            sss_pkg::KIND_DATA: byte_nxt = q_item.data_byte;
            default: ;
          endcase
        end
      end
      sss_pkg::ST_SETTLE_A, sss_pkg::ST_SETTLE_B: begin
        entry_nxt   = st_entry;
        hop_pos_nxt = st_hop;
        seg_nxt     = st_seg;
        runs_nxt    = st_runs;
        skip_nxt    = st_skip;
      end
      sss_pkg::ST_CONSUME: begin
        keep_nxt = 1'b0;
        if (!fin) begin
          if (hop_pos_r < cur_hop) begin
            hop_pos_nxt = hop_pos_r + LW'(1);
          end else if (skip_r) begin
            seg_nxt = seg_r + LW'(1);
          end else begin
            keep_nxt    = 1'b1;
            prod_nxt    = AW'(mult);
            off_cap_nxt = cur_off;
            seg_cap_nxt = seg_r;
            seg_nxt     = seg_r + LW'(1);
          end
        end
      end
      sss_pkg::ST_EMIT: emit = emit_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sss_pkg::ST_IDLE;
      entry_count_r <= 5'd0;
      entry_r       <= '0;
      hop_pos_r     <= '0;
      seg_r         <= '0;
      runs_r        <= '0;
      skip_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      entry_r   <= entry_nxt;
      hop_pos_r <= hop_pos_nxt;
      seg_r     <= seg_nxt;
      runs_r    <= runs_nxt;
      skip_r    <= skip_nxt;
      if (cfg_we) begin
        entry_count_r <= cfg_wdata;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    keep_r    <= keep_nxt;
    prod_r    <= prod_nxt;
    off_cap_r <= off_cap_nxt;
    seg_cap_r <= seg_cap_nxt;
    byte_r    <= byte_nxt;
    if (tbl_we) begin
      hop_tbl_r[wr_idx] <= LW'(q_item.hop_length);
      cnt_tbl_r[wr_idx] <= LW'(q_item.read_count);
      rd_tbl_r[wr_idx]  <= LW'(q_item.read_length);
      skp_tbl_r[wr_idx] <= LW'(q_item.skip_length);
      off_tbl_r[wr_idx] <= LW'(q_item.dest_offset);
    end
    if (emit) begin
      out_wv_r   <= keep_r;
      out_addr_r <= keep_r ? 32'(addr) : 32'd0;
      out_byte_r <= keep_r ? byte_r : 8'd0;
      out_done_r <= fin;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_valid  = out_wv_r;
  assign out_dest_address = out_addr_r;
  assign out_byte_value   = out_byte_r;
  assign out_plan_done    = out_done_r;

endmodule

// ----- hdl/strided_stream_scatter.sv -----
// Strided stream scatter, top level. A data byte passes the front queue, then the back-end
// states idle, settle A (passing finished or empty segments), consume, settle B (passing
// such segments again) and emit, into the result register that drives out_valid. The single
// back-end sequencer takes a new data byte only once it is back in idle, where table writes
// and restarts are also handled. Synchronous reset clears progress, entry_count and the
// queue; descriptor slots are unset. Depends on sss_pkg, sss_front, sss_back.
`timescale 1ns / 1ps

module strided_stream_scatter #(
  parameter int ENTRIES   = sss_pkg::ENTRIES_DEF,
  parameter int LEN_BITS  = sss_pkg::LEN_BITS_DEF,
  parameter int ADDR_BITS = sss_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: entry_count
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  // input transfers
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic [3:0]  in_entry_index,
  input  logic [15:0] in_hop_length,
  input  logic [15:0] in_read_count,
  input  logic [15:0] in_read_length,
  input  logic [15:0] in_skip_length,
  input  logic [15:0] in_dest_offset,
  // result transfers
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_write_valid,
  output logic [31:0] out_dest_address,
  output logic [7:0]  out_byte_value,
  output logic        out_plan_done
);

  // Queue between front and back lets either side stall on its own.
  logic           q_valid;
  logic           q_pop;
  sss_pkg::item_t q_item;

  // Front: take transfers, drop the unused opcode, queue the rest.
  sss_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_data_byte   (in_data_byte),
    .in_entry_index (in_entry_index),
    .in_hop_length  (in_hop_length),
    .in_read_count  (in_read_count),
    .in_read_length (in_read_length),
    .in_skip_length (in_skip_length),
    .in_dest_offset (in_dest_offset),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // Back: walk the descriptors, compute addresses, hold the result.
  sss_back #(
    .ENTRIES   (ENTRIES),
    .LEN_BITS  (LEN_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_valid  (out_write_valid),
    .out_dest_address (out_dest_address),
    .out_byte_value   (out_byte_value),
    .out_plan_done    (out_plan_done)
  );

endmodule
